// ----- src/hpis_pkg.sv -----
// Shared constants, codes and port structs of the haplotype pair selector.
`timescale 1ns / 1ps
package hpis_pkg;

    localparam int MAX_C    = 64;
    localparam int MAX_S    = 64;
    localparam int ID_BITS  = 16;
    localparam int ALLELE_W = 64;
    localparam int SEED_W   = 31;

    localparam int C_AW  = $clog2(MAX_C);
    localparam int S_AW  = $clog2(MAX_S);
    localparam int CNT_W = $clog2(MAX_C + 1);
    localparam int SC_W  = $clog2(MAX_S + 1);
    localparam int PC_W  = $clog2(MAX_C * MAX_C + 1);
    localparam int NGRP  = (MAX_S + 7) / 8;
    localparam int PAD_S = NGRP * 8;
    localparam int DIV_STEP_W = $clog2(SEED_W);

    localparam logic [1:0] FN_LOAD_MAT  = 2'd0;
    localparam logic [1:0] FN_LOAD_PAT  = 2'd1;
    localparam logic [1:0] FN_LOAD_GENO = 2'd2;
    localparam logic [1:0] FN_START     = 2'd3;

    typedef struct packed {
        logic                mat_we;
        logic                pat_we;
        logic                geno_we;
        logic [C_AW-1:0]     hap_addr;
        logic [S_AW-1:0]     geno_addr;
        logic [ALLELE_W-1:0] bits;
        logic [ID_BITS-1:0]  id;
        logic [1:0]          geno;
    } t_wr_req;

    typedef struct packed {
        logic [C_AW-1:0] mat_addr;
        logic [C_AW-1:0] pat_addr;
        logic [S_AW-1:0] geno_addr;
    } t_rd_req;

endpackage

// ----- src/hpis_store.sv -----
// Candidate haplotype and genotype memories with registered read ports.
`timescale 1ns / 1ps
module hpis_store import hpis_pkg::*; (
    input  logic                i_clk,
    input  t_wr_req             i_wr,
    input  t_rd_req             i_rd,
    output logic [ALLELE_W-1:0] o_mat_bits,
    output logic [ID_BITS-1:0]  o_mat_id,
    output logic [ALLELE_W-1:0] o_pat_bits,
    output logic [ID_BITS-1:0]  o_pat_id,
    output logic [1:0]          o_geno
);

    logic [ALLELE_W-1:0] mat_bits_mem [MAX_C];
    logic [ID_BITS-1:0]  mat_id_mem   [MAX_C];
    logic [ALLELE_W-1:0] pat_bits_mem [MAX_C];
    logic [ID_BITS-1:0]  pat_id_mem   [MAX_C];
    logic [1:0]          geno_mem     [MAX_S];

    always_ff @(posedge i_clk) begin
        if (i_wr.mat_we) begin
            mat_bits_mem[i_wr.hap_addr] <= i_wr.bits;
            mat_id_mem[i_wr.hap_addr]   <= i_wr.id;
        end
        if (i_wr.pat_we) begin
            pat_bits_mem[i_wr.hap_addr] <= i_wr.bits;
            pat_id_mem[i_wr.hap_addr]   <= i_wr.id;
        end
        if (i_wr.geno_we) begin
            geno_mem[i_wr.geno_addr] <= i_wr.geno;
        end
        o_mat_bits <= mat_bits_mem[i_rd.mat_addr];
        o_mat_id   <= mat_id_mem[i_rd.mat_addr];
        o_pat_bits <= pat_bits_mem[i_rd.pat_addr];
        o_pat_id   <= pat_id_mem[i_rd.pat_addr];
        o_geno     <= geno_mem[i_rd.geno_addr];
    end

endmodule

// ----- src/hpis_mod.sv -----
// Bit-serial restoring remainder of the seed by the tie count.
`timescale 1ns / 1ps
module hpis_mod import hpis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_dividend,
    input  logic [PC_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [PC_W-1:0]   o_rem
);

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_step;
    logic [PC_W-1:0]       r_rem;
    logic [SEED_W-1:0]     r_dvd;
    logic [PC_W-1:0]       r_div;
    logic [PC_W:0]         n_trial;
    logic [PC_W:0]         n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[SEED_W-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = n_trial - {1'b0, r_div};
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_step == DIV_STEP_W'(SEED_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // The remainder stays below the divisor, so it fits PC_W bits.
                r_rem  <= n_rem[PC_W-1:0];
                r_dvd  <= {r_dvd[SEED_W-2:0], 1'b0};
                r_step <= r_step + DIV_STEP_W'(1);
                if (r_step == DIV_STEP_W'(SEED_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rem = r_rem;

endmodule

// ----- src/haplotype_pair_imputation_select.sv -----
// Top level: command decode, pair walk pipeline and result register.
`timescale 1ns / 1ps
// Usage. A beat is taken at a rising edge where start is high and busy is
// low; i_func selects the command. Load commands (maternal haplotype,
// paternal haplotype, genotype of one site) write one memory entry in that
// cycle, give no result, and leave busy low, so loads run one per cycle.
// A start command captures the candidate counts, site count, previous ids
// and seed, raises busy and walks the stored candidates. It first copies
// the genotype memory into per-class site masks, then walks all
// maternal/paternal pairs through a four-stage read and score pipeline,
// one pair per cycle, tracking the top score, the top id points among
// top-score pairs and their count. A serial remainder unit then forms
// seed mod count, a second walk finds the pair at that index, and the
// chosen entry is read back once more for the result. Each memory has a
// single read port, so the walks take one pair per cycle.
// An empty candidate set answers in the cycle after start with status set.
// The result is on the o_ ports for one cycle, marked by o_valid; the
// receiver cannot stall, so nothing waits. Synchronous reset clears the
// control state and drops busy; the memories keep their contents and are
// undefined until written.
module haplotype_pair_imputation_select import hpis_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_func,
    input  logic [5:0]          i_slot,
    input  logic [63:0]         i_alleles,
    input  logic [15:0]         i_hap_id,
    input  logic [1:0]          i_genotype,
    input  logic [6:0]          i_num_mat,
    input  logic [6:0]          i_num_pat,
    input  logic [6:0]          i_num_sites,
    input  logic [15:0]         i_prev_mat_id,
    input  logic [15:0]         i_prev_pat_id,
    input  logic [30:0]         i_seed,
    output logic                o_valid,
    output logic [5:0]          o_mat_slot,
    output logic [5:0]          o_pat_slot,
    output logic [15:0]         o_mat_id,
    output logic [15:0]         o_pat_id,
    output logic [63:0]         o_mat_bits,
    output logic [63:0]         o_pat_bits,
    output logic [6:0]          o_site_score,
    output logic                o_status
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_GSWEEP, ST_WALK1, ST_DIV, ST_WALK3, ST_FETCH, ST_FETCH2
    } t_state;

    typedef struct packed {
        logic            v;
        logic [C_AW-1:0] m;
        logic [C_AW-1:0] p;
        logic [1:0]      pts;
    } t_tag;

    t_state r_state;

    // Captured start operands.
    logic [CNT_W-1:0]   r_nm, r_np;
    logic [MAX_S-1:0]   r_smask;
    logic [ID_BITS-1:0] r_pm, r_pp;
    logic [SEED_W-1:0]  r_seed;

    // Genotype class masks built by the sweep.
    logic [MAX_S-1:0] r_g0, r_g1, r_g2;
    logic [S_AW:0]    r_gcnt;
    logic             r_gv;
    logic [S_AW-1:0]  r_gidx;

    // Pair issue counters and pipeline stages.
    logic             r_issuing;
    logic [C_AW-1:0]  r_im, r_ip;
    t_tag             r_t1, r_t2, r_t3, r_t4;
    logic [PAD_S-1:0] r_mask2;
    logic [3:0]       r_grp3 [NGRP];
    logic [SC_W-1:0]  r_score4;

    // Running selection.
    logic             r_any;
    logic [SC_W-1:0]  r_best;
    logic [1:0]       r_bestpts;
    logic [PC_W-1:0]  r_cnt;
    logic [PC_W-1:0]  r_idx;
    logic [PC_W-1:0]  r_pick;
    logic [C_AW-1:0]  r_fm, r_fp;

    logic                accept;
    t_wr_req             wr;
    t_rd_req             rd;
    logic [ALLELE_W-1:0] mat_bits, pat_bits;
    logic [ID_BITS-1:0]  mat_id, pat_id;
    logic [1:0]          geno;
    logic                div_start, div_done;
    logic [PC_W-1:0]     div_rem;

    logic [CNT_W-1:0]  n_nm, n_np;
    logic [MAX_S-1:0]  n_smask;
    logic [PAD_S-1:0]  n_mask;
    logic [1:0]        n_pts;
    logic [3:0]        n_grp [NGRP];
    logic [SC_W-1:0]   n_score;
    logic              walking, issue_last, pipe_empty;
    logic              empty_start;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        wr           = '0;
        wr.hap_addr  = C_AW'(i_slot);
        wr.geno_addr = S_AW'(i_slot);
        wr.bits      = i_alleles;
        wr.id        = ID_BITS'(i_hap_id);
        wr.geno      = i_genotype;
        // Loads to a slot beyond the store depth are dropped.
        if (accept && (int'(i_slot) < MAX_C)) begin
            wr.mat_we = (i_func == FN_LOAD_MAT);
            wr.pat_we = (i_func == FN_LOAD_PAT);
        end
        if (accept && (int'(i_slot) < MAX_S)) begin
            wr.geno_we = (i_func == FN_LOAD_GENO);
        end
    end

    always_comb begin
        rd.mat_addr  = (r_state == ST_FETCH) ? r_fm : r_im;
        rd.pat_addr  = (r_state == ST_FETCH) ? r_fp : r_ip;
        rd.geno_addr = r_gcnt[S_AW-1:0];
    end

    hpis_store u_store (
        .i_clk      (i_clk),
        .i_wr       (wr),
        .i_rd       (rd),
        .o_mat_bits (mat_bits),
        .o_mat_id   (mat_id),
        .o_pat_bits (pat_bits),
        .o_pat_id   (pat_id),
        .o_geno     (geno)
    );

    assign div_start = (r_state == ST_WALK1) && !r_issuing && pipe_empty;

    hpis_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_seed),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Start operand saturation and the site mask.
    always_comb begin
        n_nm = (int'(i_num_mat) > MAX_C) ? CNT_W'(MAX_C) : CNT_W'(i_num_mat);
        n_np = (int'(i_num_pat) > MAX_C) ? CNT_W'(MAX_C) : CNT_W'(i_num_pat);
        for (int k = 0; k < MAX_S; k++) begin
            n_smask[k] = (k < int'(i_num_sites));
        end
    end

    // A start with no maternal or no paternal candidates is answered at once.
    assign empty_start = accept && (i_func == FN_START)
                      && ((n_nm == '0) || (n_np == '0));

    // Stage one: per-site match mask and id points from the memory data.
    always_comb begin
        logic [MAX_S-1:0] a, b, hit;
        a = mat_bits[MAX_S-1:0];
        b = pat_bits[MAX_S-1:0];
        hit = ((~a & ~b & r_g0) | ((a ^ b) & r_g1) | (a & b & r_g2)) & r_smask;
        n_mask = PAD_S'(hit);
        n_pts  = {1'b0, (mat_id == r_pm)} + {1'b0, (pat_id == r_pp)};
    end

    // Stage two: popcount of each byte of the mask.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < 8; k++) begin
                n_grp[g] = n_grp[g] + 4'(r_mask2[g*8 + k]);
            end
        end
    end

    // Stage three: sum of the byte counts.
    always_comb begin
        n_score = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_score = n_score + SC_W'(r_grp3[g]);
        end
    end

    assign walking    = (r_state == ST_WALK1) || (r_state == ST_WALK3);
    assign issue_last = (CNT_W'(r_ip) + CNT_W'(1) == r_np)
                     && (CNT_W'(r_im) + CNT_W'(1) == r_nm);
    assign pipe_empty = !r_t1.v && !r_t2.v && !r_t3.v && !r_t4.v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issuing <= 1'b0;
            r_gv      <= 1'b0;
            r_t1.v    <= 1'b0;
            r_t2.v    <= 1'b0;
            r_t3.v    <= 1'b0;
            r_t4.v    <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= empty_start || (r_state == ST_FETCH2);

            // Pair pipeline, advancing every cycle.
            r_t1.v   <= r_issuing && walking;
            r_t1.m   <= r_im;
            r_t1.p   <= r_ip;
            r_t1.pts <= '0;
            r_t2     <= {r_t1.v, r_t1.m, r_t1.p, n_pts};
            r_mask2  <= n_mask;
            r_t3     <= r_t2;
            r_grp3   <= n_grp;
            r_t4     <= r_t3;
            r_score4 <= n_score;

            if (r_issuing && walking) begin
                if (CNT_W'(r_ip) + CNT_W'(1) == r_np) begin
                    r_ip <= '0;
                    r_im <= r_im + C_AW'(1);
                end else begin
                    r_ip <= r_ip + C_AW'(1);
                end
                if (issue_last) begin
                    r_issuing <= 1'b0;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_func == FN_START)) begin
                        r_nm    <= n_nm;
                        r_np    <= n_np;
                        r_smask <= n_smask;
                        r_pm    <= ID_BITS'(i_prev_mat_id);
                        r_pp    <= ID_BITS'(i_prev_pat_id);
                        r_seed  <= i_seed;
                        if (empty_start) begin
                            // No pairs to choose from: report it at once.
                            o_status     <= 1'b1;
                            o_mat_slot   <= '0;
                            o_pat_slot   <= '0;
                            o_mat_id     <= '0;
                            o_pat_id     <= '0;
                            o_mat_bits   <= '0;
                            o_pat_bits   <= '0;
                            o_site_score <= '0;
                        end else begin
                            r_gcnt  <= '0;
                            r_gv    <= 1'b0;
                            r_state <= ST_GSWEEP;
                        end
                    end
                end
                ST_GSWEEP: begin
                    // Copy the genotype memory into one mask per allele count.
                    r_gv   <= (int'(r_gcnt) < MAX_S);
                    r_gidx <= r_gcnt[S_AW-1:0];
                    if (int'(r_gcnt) < MAX_S) begin
                        r_gcnt <= r_gcnt + (S_AW+1)'(1);
                    end
                    if (r_gv) begin
                        r_g0[r_gidx] <= (geno == 2'd0);
                        r_g1[r_gidx] <= (geno == 2'd1);
                        r_g2[r_gidx] <= (geno == 2'd2);
                    end else if (int'(r_gcnt) >= MAX_S) begin
                        r_im      <= '0;
                        r_ip      <= '0;
                        r_issuing <= 1'b1;
                        r_any     <= 1'b0;
                        r_state   <= ST_WALK1;
                    end
                end
                ST_WALK1: begin
                    if (r_t4.v) begin
                        if (!r_any || (r_score4 > r_best)) begin
                            r_any     <= 1'b1;
                            r_best    <= r_score4;
                            r_bestpts <= r_t4.pts;
                            r_cnt     <= PC_W'(1);
                        end else if (r_score4 == r_best) begin
                            if (r_t4.pts > r_bestpts) begin
                                r_bestpts <= r_t4.pts;
                                r_cnt     <= PC_W'(1);
                            end else if (r_t4.pts == r_bestpts) begin
                                r_cnt <= r_cnt + PC_W'(1);
                            end
                        end
                    end
                    if (div_start) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_pick    <= div_rem;
                        r_idx     <= '0;
                        r_im      <= '0;
                        r_ip      <= '0;
                        r_issuing <= 1'b1;
                        r_state   <= ST_WALK3;
                    end
                end
                ST_WALK3: begin
                    if (r_t4.v && (r_score4 == r_best) && (r_t4.pts == r_bestpts)) begin
                        r_idx <= r_idx + PC_W'(1);
                        if (r_idx == r_pick) begin
                            r_fm    <= r_t4.m;
                            r_fp    <= r_t4.p;
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    // The walk is over; stop any pair issue still pending.
                    r_issuing <= 1'b0;
                    r_state   <= ST_FETCH2;
                end
                ST_FETCH2: begin
                    o_status     <= 1'b0;
                    o_mat_slot   <= 6'(r_fm);
                    o_pat_slot   <= 6'(r_fp);
                    o_mat_id     <= 16'(mat_id);
                    o_pat_id     <= 16'(pat_id);
                    o_mat_bits   <= mat_bits;
                    o_pat_bits   <= pat_bits;
                    o_site_score <= 7'(r_best);
                    r_state      <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sim/haplotype_pair_imputation_select_tb.sv -----
// Testbench for the haplotype pair selector: directed and random beats against a predictor.
`timescale 1ns / 1ps
module haplotype_pair_imputation_select_tb;
    import hpis_pkg::*;

    // Generous cycle limit. Only a handful of the slowest starts are issued;
    // everything else uses small sets.
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 200;

    // Expected content of one result beat.
    typedef struct {
        logic [5:0]  mat_slot;
        logic [5:0]  pat_slot;
        logic [15:0] mat_id;
        logic [15:0] pat_id;
        logic [63:0] mat_bits;
        logic [63:0] pat_bits;
        logic [6:0]  site_score;
        logic        status;
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = FN_LOAD_MAT;
    logic [5:0]  i_slot = '0;
    logic [63:0] i_alleles = '0;
    logic [15:0] i_hap_id = '0;
    logic [1:0]  i_genotype = '0;
    logic [6:0]  i_num_mat = '0;
    logic [6:0]  i_num_pat = '0;
    logic [6:0]  i_num_sites = '0;
    logic [15:0] i_prev_mat_id = '0;
    logic [15:0] i_prev_pat_id = '0;
    logic [30:0] i_seed = '0;
    logic        o_valid;
    logic [5:0]  o_mat_slot;
    logic [5:0]  o_pat_slot;
    logic [15:0] o_mat_id;
    logic [15:0] o_pat_id;
    logic [63:0] o_mat_bits;
    logic [63:0] o_pat_bits;
    logic [6:0]  o_site_score;
    logic        o_status;

    haplotype_pair_imputation_select dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The predictor keeps its own copy of the candidate and genotype memories.
    logic [63:0] mat_bits_mem [MAX_C];
    logic [15:0] mat_id_mem   [MAX_C];
    logic [63:0] pat_bits_mem [MAX_C];
    logic [15:0] pat_id_mem   [MAX_C];
    logic [1:0]  geno_mem     [MAX_S];

    t_pick pending_picks [$];
    int    mismatches = 0;
    int    picks_checked = 0;
    int    loads_sent = 0;
    int    starts_sent = 0;
    int    empty_starts = 0;
    int    cycle_count = 0;
    bit    quiet_sender = 1'b0;

    // Count of the first ns sites where the two allele bits add up to the
    // stored genotype. A missing genotype (3) can never be reached by a sum.
    function automatic int pair_match_count(int m, int p, int ns);
        int total;
        total = 0;
        for (int k = 0; k < ns; k++) begin
            if (int'(mat_bits_mem[m][k]) + int'(pat_bits_mem[p][k]) == int'(geno_mem[k]))
                total++;
        end
        return total;
    endfunction

    function automatic int id_match_points(int m, int p, logic [15:0] pm, logic [15:0] pp);
        return int'(mat_id_mem[m] == pm) + int'(pat_id_mem[p] == pp);
    endfunction

    // Selection of one start: top score first, then top id points among the
    // top-score pairs, then the seed picks one of the survivors in walk order.
    function automatic t_pick predict_pick(logic [6:0] nm_in, logic [6:0] np_in,
                                           logic [6:0] ns_in, logic [15:0] pm,
                                           logic [15:0] pp, logic [30:0] seed);
        t_pick r;
        int nm, np, ns;
        int best, best_pts, count, pick, idx, pts;
        int score [MAX_C][MAX_C];
        nm = (nm_in > MAX_C) ? MAX_C : int'(nm_in);
        np = (np_in > MAX_C) ? MAX_C : int'(np_in);
        ns = (ns_in > MAX_S) ? MAX_S : int'(ns_in);
        r = '{default: '0};
        if (nm == 0 || np == 0) begin
            r.status = 1'b1;
            return r;
        end
        best = 0;
        for (int m = 0; m < nm; m++)
            for (int p = 0; p < np; p++) begin
                score[m][p] = pair_match_count(m, p, ns);
                if (score[m][p] > best) best = score[m][p];
            end
        best_pts = -1;
        count = 0;
        for (int m = 0; m < nm; m++)
            for (int p = 0; p < np; p++) begin
                if (score[m][p] != best) continue;
                pts = id_match_points(m, p, pm, pp);
                if (pts > best_pts) begin
                    best_pts = pts;
                    count = 1;
                end else if (pts == best_pts) begin
                    count++;
                end
            end
        pick = int'(seed % 31'(count));
        idx = 0;
        for (int m = 0; m < nm; m++)
            for (int p = 0; p < np; p++) begin
                if (score[m][p] != best || id_match_points(m, p, pm, pp) != best_pts)
                    continue;
                if (idx == pick) begin
                    r.mat_slot   = 6'(m);
                    r.pat_slot   = 6'(p);
                    r.mat_id     = mat_id_mem[m];
                    r.pat_id     = pat_id_mem[p];
                    r.mat_bits   = mat_bits_mem[m];
                    r.pat_bits   = pat_bits_mem[p];
                    r.site_score = 7'(best);
                end
                idx++;
            end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what,
                 got, want);
    endtask

    // Sends one beat. The start strobe is lowered only when an idle gap is
    // drawn, so a back-to-back beat never sees two updates in one step.
    task automatic send_beat(logic [1:0] func, logic [5:0] slot, logic [63:0] alleles,
                             logic [15:0] hap_id, logic [1:0] geno, logic [6:0] nm,
                             logic [6:0] np, logic [6:0] ns, logic [15:0] pm,
                             logic [15:0] pp, logic [30:0] seed);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_slot        <= slot;
        i_alleles     <= alleles;
        i_hap_id      <= hap_id;
        i_genotype    <= geno;
        i_num_mat     <= nm;
        i_num_pat     <= np;
        i_num_sites   <= ns;
        i_prev_mat_id <= pm;
        i_prev_pat_id <= pp;
        i_seed        <= seed;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // The beat is taken at this edge; update the predictor in order.
        case (func)
            FN_LOAD_MAT: begin
                mat_bits_mem[slot] = alleles;
                mat_id_mem[slot]   = hap_id;
                loads_sent++;
            end
            FN_LOAD_PAT: begin
                pat_bits_mem[slot] = alleles;
                pat_id_mem[slot]   = hap_id;
                loads_sent++;
            end
            FN_LOAD_GENO: begin
                geno_mem[slot] = geno;
                loads_sent++;
            end
            default: begin
                pending_picks = {pending_picks, predict_pick(nm, np, ns, pm, pp, seed)};
                starts_sent++;
                if (nm == 0 || np == 0) empty_starts++;
            end
        endcase
    endtask

    task automatic load_hap(logic [1:0] func, logic [5:0] slot, logic [63:0] bits,
                            logic [15:0] id);
        send_beat(func, slot, bits, id, 2'd0, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic load_geno(logic [5:0] site, logic [1:0] geno);
        send_beat(FN_LOAD_GENO, site, '0, '0, geno, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic start_pick(logic [6:0] nm, logic [6:0] np, logic [6:0] ns,
                              logic [15:0] pm, logic [15:0] pp, logic [30:0] seed);
        send_beat(FN_START, '0, '0, '0, '0, nm, np, ns, pm, pp, seed);
    endtask

    // Lowers start and waits until every expected result has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0) @(posedge i_clk);
    endtask

    // Allele values drawn from a small pool so that scores tie often.
    function automatic logic [63:0] draw_alleles();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'haaaa_5555_f0f0_0f0f;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Identifiers from a small pool so the previous-pair match hits often.
    function automatic logic [15:0] draw_id();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
    endfunction

    // Every memory entry is written once first, so no start ever reads an
    // entry that was never written, whatever counts it asks for.
    task automatic test_fill_memories();
        for (int i = 0; i < MAX_C; i++) begin
            load_hap(FN_LOAD_MAT, 6'(i), draw_alleles(), draw_id());
            load_hap(FN_LOAD_PAT, 6'(i), draw_alleles(), draw_id());
            load_geno(6'(i), 2'($urandom_range(0, 3)));
        end
        wait_for_results();
    endtask

    // Extreme field values and the empty candidate set.
    task automatic test_extremes();
        load_hap(FN_LOAD_MAT, 6'd63, '1, 16'hffff);
        load_hap(FN_LOAD_PAT, 6'd0, '0, 16'h0000);
        load_geno(6'd63, 2'd2);
        load_geno(6'd0, 2'd0);
        start_pick(7'd0, 7'd5, 7'd10, 16'h0, 16'h0, 31'd3);
        start_pick(7'd5, 7'd0, 7'd10, 16'hffff, 16'hffff, 31'h7fffffff);
        start_pick(7'd0, 7'd0, 7'd0, 16'h1, 16'h2, 31'd0);
        start_pick(7'd3, 7'd4, 7'd0, 16'h1, 16'h2, 31'd0);
        start_pick(7'd4, 7'd3, 7'd64, 16'h0, 16'h1, 31'h7fffffff);
        start_pick(7'd2, 7'd2, 7'd127, 16'hffff, 16'h0, 31'd12345);
        wait_for_results();
        // Counts beyond the candidate limit saturate; one full walk each way.
        start_pick(7'd64, 7'd64, 7'd64, 16'h1, 16'h1, 31'd77);
        start_pick(7'd127, 7'd1, 7'd100, 16'h0, 16'h3, 31'h5555_5555);
        start_pick(7'd1, 7'd127, 7'd33, 16'h2, 16'h0, 31'h2aaa_aaaa);
        wait_for_results();
    endtask

    // Missing genotypes never match: every pair scores zero and all tie on the score.
    task automatic test_missing_genotypes();
        for (int k = 0; k < 8; k++) load_geno(6'(k), 2'd3);
        start_pick(7'd4, 7'd4, 7'd8, 16'h1, 16'h2, 31'd9);
        start_pick(7'd4, 7'd4, 7'd8, 16'hffff, 16'hffff, 31'd15);
        wait_for_results();
    endtask

    // Random loads and starts, mostly small sets, with the odd large one.
    task automatic test_random_traffic(int beats);
        int roll;
        logic [6:0] nm, np;
        for (int n = 0; n < beats; n++) begin
            if (n % 100 == 0) quiet_sender = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                load_hap(FN_LOAD_MAT, 6'($urandom()), draw_alleles(), draw_id());
            end else if (roll < 50) begin
                load_hap(FN_LOAD_PAT, 6'($urandom()), draw_alleles(), draw_id());
            end else if (roll < 70) begin
                load_geno(6'($urandom()), 2'($urandom()));
            end else begin
                if ($urandom_range(0, 199) == 0) begin
                    nm = 7'($urandom());
                    np = 7'($urandom_range(0, 3));
                end else begin
                    nm = 7'($urandom_range(0, 6));
                    np = 7'($urandom_range(0, 6));
                end
                start_pick(nm, np, 7'($urandom()), draw_id(), draw_id(),
                           31'($urandom()));
            end
            // The sender holds off now and then until everything is back.
            if ($urandom_range(0, 99) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    // Checks each result beat against the oldest expected pick.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_picks.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(o_status), 64'd0);
            end else begin
                t_pick want;
                want = pending_picks.pop_front();
                picks_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_mat_slot !== want.mat_slot)
                    report_mismatch("mat_slot", 64'(o_mat_slot), 64'(want.mat_slot));
                if (o_pat_slot !== want.pat_slot)
                    report_mismatch("pat_slot", 64'(o_pat_slot), 64'(want.pat_slot));
                if (o_mat_id !== want.mat_id)
                    report_mismatch("mat_id", 64'(o_mat_id), 64'(want.mat_id));
                if (o_pat_id !== want.pat_id)
                    report_mismatch("pat_id", 64'(o_pat_id), 64'(want.pat_id));
                if (o_mat_bits !== want.mat_bits)
                    report_mismatch("mat_bits", o_mat_bits, want.mat_bits);
                if (o_pat_bits !== want.pat_bits)
                    report_mismatch("pat_bits", o_pat_bits, want.pat_bits);
                if (o_site_score !== want.site_score)
                    report_mismatch("site_score", 64'(o_site_score), 64'(want.site_score));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_picks.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_memories();
        test_extremes();
        test_missing_genotypes();
        test_random_traffic(1335);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d loads and %0d starts (%0d with an empty set), %0d results checked",
                 loads_sent, starts_sent, empty_starts, picks_checked);
        if (mismatches == 0 && pending_picks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
